// ===== rtl/core/cspl_pkg.sv =====
// ----------------------------------------------------------------------------
// cspl_pkg
// Types and constants shared by the convex sector point locator, its checker and its test.
// ----------------------------------------------------------------------------
package cspl_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int CNT_W   = 5;
  localparam int SEC_IDX_W = 4;
  localparam int WALL_IDX_W = 4;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // register index decoded from paddr[2]
  localparam logic REG_SECTOR_COUNT = 1'b0;

  typedef struct packed {
    logic                      cmd;
    logic [SEC_IDX_W-1:0]      sector_sel;
    logic [WALL_IDX_W-1:0]     wall_sel;
    logic                      wall_last;
    logic signed [COORD_W-1:0] x_start;
    logic signed [COORD_W-1:0] y_start;
    logic signed [COORD_W-1:0] x_end;
    logic signed [COORD_W-1:0] y_end;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic                 found;
    logic [SEC_IDX_W-1:0] sector_index;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] xs;
    logic signed [COORD_W-1:0] ys;
    logic signed [COORD_W-1:0] xe;
    logic signed [COORD_W-1:0] ye;
  } wall_t;

  localparam int WALL_BITS = $bits(wall_t);

  // tag that travels with each wall through the cross product pipeline
  typedef struct packed {
    logic                 is_last;
    logic                 is_empty;
    logic                 is_end;
    logic [SEC_IDX_W-1:0] sec;
  } tag_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_RESULT
  } state_t;

endpackage

// ===== rtl/core/cspl_ram.sv =====
// ----------------------------------------------------------------------------
// cspl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cspl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/convex_sector_point_locator.sv =====
// ----------------------------------------------------------------------------
// convex_sector_point_locator
// Finds the first convex sector (list of directed walls) that holds a point.
// ----------------------------------------------------------------------------
// Input beats on in_data are loads (cmd 0: one wall into a sector slot, and
// with wall_last the sector's wall count) or queries (cmd 1: a point).
// A load is taken only while idle and gives no output beat. A query walks the
// sectors below sector_count (at most MAX_SECTORS) and gives one out_data
// beat: found and the first sector whose walls all see the point on their
// non-positive side. One shared pair of 17x17 multipliers forms one wall
// cross product per cycle, fed from the wall RAM one read per cycle, with a
// three stage pipeline (RAM read, multiply, compare). A query reads every
// wall of each searched sector in turn, or one slot of an empty sector, and
// ends early at the first match. in_stall is high while a query is in
// progress. A finished result sits in the output register while out_stall
// is high; a next load or query is still taken meanwhile, but a second
// result waits behind it. Reset clears all wall counts and sector_count;
// the wall RAM holds garbage until written. sector_count is written
// through the APB port.
// ----------------------------------------------------------------------------
module convex_sector_point_locator #(
  parameter int MAX_SECTORS = 16,
  parameter int MAX_WALLS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cspl_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cspl_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import cspl_pkg::*;

  // sector_sel and wall_sel are four bits, so no more than 16 of either is reachable
  localparam int SEC_N    = (MAX_SECTORS < 16) ? MAX_SECTORS : 16;
  localparam int WALL_N   = (MAX_WALLS < 16) ? MAX_WALLS : 16;
  localparam int SA_W     = (SEC_N > 1) ? $clog2(SEC_N) : 1;
  localparam int WA_W     = $clog2(WALL_N);
  localparam int ADDR_W   = SA_W + WA_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;
  localparam logic [CNT_W-1:0] SEC_CAP = CNT_W'((MAX_SECTORS < 31) ? MAX_SECTORS : 31);
  localparam logic [CNT_W-1:0] SEC_N_C = CNT_W'(SEC_N);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] sector_count_r;
  logic [CNT_W-1:0] wall_cnt_r [SEC_N];

  logic [CNT_W-1:0] s_r, s_nxt;
  logic [WA_W-1:0]  w_r, w_nxt;
  logic signed [COORD_W-1:0] px_r, py_r;

  logic rd_v_r, rd_v_nxt;
  tag_t rd_tag_r, rd_tag_nxt;
  logic m_v_r, m_v_nxt;
  tag_t m_tag_r;
  logic signed [PROD_W-1:0] prod_a_r, prod_b_r;
  logic rej_acc_r, rej_acc_nxt;

  out_item_t res_r, res_nxt;
  logic      out_valid_r;
  out_item_t out_data_r;

  // configuration port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_SECTOR_COUNT) ? {27'b0, sector_count_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_count_r <= '0;
    end else if (cfg_wr && paddr[2] == REG_SECTOR_COUNT) begin
      sector_count_r <= pwdata[CNT_W-1:0];
    end
  end

  // input side
  logic in_acc, load_acc, query_acc, load_ok;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign load_acc  = in_acc && in_data.cmd == CMD_LOAD;
  assign query_acc = in_acc && in_data.cmd == CMD_QUERY;
  assign load_ok   = (32'(in_data.sector_sel) < MAX_SECTORS) &&
                     (32'(in_data.wall_sel) < MAX_WALLS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SEC_N; i++) begin
        wall_cnt_r[i] <= '0;
      end
    end else if (load_acc && load_ok && in_data.wall_last) begin
      wall_cnt_r[in_data.sector_sel[SA_W-1:0]] <= CNT_W'(in_data.wall_sel) + 1'b1;
    end
  end

  // wall store
  wall_t            ram_wdata, ram_rdata;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [WALL_BITS-1:0] ram_rbits;

  assign ram_wdata = '{xs: in_data.x_start, ys: in_data.y_start,
                       xe: in_data.x_end,   ye: in_data.y_end};
  assign ram_waddr = {in_data.sector_sel[SA_W-1:0], in_data.wall_sel[WA_W-1:0]};
  assign ram_raddr = {s_r[SA_W-1:0], w_r};
  assign ram_rdata = wall_t'(ram_rbits);

  cspl_ram #(
    .WIDTH (WALL_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_wall_ram (
    .clk   (clk),
    .we    (load_acc && load_ok),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  // search limit and current sector's wall count
  logic [CNT_W-1:0] limit, cur_cnt;
  assign limit   = (sector_count_r > SEC_CAP) ? SEC_CAP : sector_count_r;
  assign cur_cnt = (s_r < SEC_N_C) ? wall_cnt_r[s_r[SA_W-1:0]] : '0;

  // multiply stage
  logic signed [DIFF_W-1:0] dx, dy, qx, qy;
  assign dx = DIFF_W'(ram_rdata.xe) - DIFF_W'(ram_rdata.xs);
  assign dy = DIFF_W'(ram_rdata.ye) - DIFF_W'(ram_rdata.ys);
  assign qx = DIFF_W'(px_r) - DIFF_W'(ram_rdata.xs);
  assign qy = DIFF_W'(py_r) - DIFF_W'(ram_rdata.ys);

  always_ff @(posedge clk) begin
    prod_a_r <= dx * qy;
    prod_b_r <= dy * qx;
    m_tag_r  <= rd_tag_r;
    rd_tag_r <= rd_tag_nxt;
  end

  // compare stage
  logic signed [CROSS_W-1:0] cross_val;
  logic rej_now, hit, decide;
  assign cross_val = CROSS_W'(prod_a_r) - CROSS_W'(prod_b_r);
  assign rej_now   = !m_tag_r.is_empty && !cross_val[CROSS_W-1] && (cross_val != '0);
  assign hit       = !(rej_acc_r || rej_now);
  assign decide    = m_v_r && m_tag_r.is_last && (hit || m_tag_r.is_end);

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    logic issue_last;
    state_nxt   = state_r;
    s_nxt       = s_r;
    w_nxt       = w_r;
    rd_v_nxt    = 1'b0;
    rd_tag_nxt  = '0;
    m_v_nxt     = rd_v_r;
    rej_acc_nxt = rej_acc_r;
    res_nxt     = res_r;
    issue_last  = (cur_cnt == '0) || (CNT_W'(w_r) + 1'b1 == cur_cnt);

    if (m_v_r) begin
      rej_acc_nxt = m_tag_r.is_last ? 1'b0 : (rej_acc_r || rej_now);
    end

    case (state_r)
      ST_IDLE: begin
        if (query_acc) begin
          s_nxt       = '0;
          w_nxt       = '0;
          rej_acc_nxt = 1'b0;
          if (limit == '0) begin
            res_nxt   = '{found: 1'b0, sector_index: '0};
            state_nxt = ST_RESULT;
          end else begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        rd_v_nxt            = 1'b1;
        rd_tag_nxt.is_last  = issue_last;
        rd_tag_nxt.is_empty = (cur_cnt == '0);
        rd_tag_nxt.is_end   = issue_last && (s_r + 1'b1 == limit);
        rd_tag_nxt.sec      = s_r[SEC_IDX_W-1:0];
        if (issue_last) begin
          w_nxt = '0;
          s_nxt = s_r + 1'b1;
          if (s_r + 1'b1 == limit) begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          w_nxt = w_r + 1'b1;
        end
      end
      ST_DRAIN: begin
      end
      ST_RESULT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // first matching sector or end of search: flush what is still in flight
    if (decide) begin
      res_nxt   = '{found: hit, sector_index: hit ? m_tag_r.sec : '0};
      state_nxt = ST_RESULT;
      rd_v_nxt  = 1'b0;
      m_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_v_r    <= 1'b0;
      m_v_r     <= 1'b0;
      rej_acc_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_v_r    <= rd_v_nxt;
      m_v_r     <= m_v_nxt;
      rej_acc_r <= rej_acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r   <= s_nxt;
    w_r   <= w_nxt;
    res_r <= res_nxt;
    if (query_acc) begin
      px_r <= in_data.point_x;
      py_r <= in_data.point_y;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_RESULT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RESULT && out_free) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== test/convex_sector_point_locator_checker.sv =====
// ----------------------------------------------------------------------------
// convex_sector_point_locator_checker
// Watches the input, result and register ports of the sector locator. It keeps
// its own copy of the wall table, the wall counts and sector_count, works out
// the lookup answer for every query beat and compares each result beat, field
// by field, with the oldest answer still owed. It also checks register reads.
// ----------------------------------------------------------------------------
module convex_sector_point_locator_checker #(
  parameter int MAX_SECTORS = 16,
  parameter int MAX_WALLS   = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  cspl_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  cspl_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic [31:0]         prdata,
  input  logic                pready,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import cspl_pkg::*;

  localparam logic [2:0] SECTOR_COUNT_ADDR = {REG_SECTOR_COUNT, 2'b00};

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
  } edge_rec_t;

  edge_rec_t   wall_table [MAX_SECTORS*MAX_WALLS];
  logic [4:0]  wall_total [MAX_SECTORS];
  logic [4:0]  sector_cfg;
  out_item_t   owed_answers [$];
  int          errs = 0;

  // exact cross product of the wall direction with the point offset
  function automatic longint wall_side(input edge_rec_t e, input logic signed [15:0] px,
                                       input logic signed [15:0] py);
    longint ex, ey, qx, qy;
    ex = longint'(e.bx) - longint'(e.ax);
    ey = longint'(e.by) - longint'(e.ay);
    qx = longint'(px) - longint'(e.ax);
    qy = longint'(py) - longint'(e.ay);
    return ex * qy - ey * qx;
  endfunction

  function automatic out_item_t locate_point(input logic signed [15:0] px,
                                             input logic signed [15:0] py);
    out_item_t ans;
    int        lim;
    int        n;
    bit        covered;
    ans = '0;
    lim = (int'(sector_cfg) > MAX_SECTORS) ? MAX_SECTORS : int'(sector_cfg);
    for (int s = 0; s < lim; s++) begin
      n = (int'(wall_total[s]) > MAX_WALLS) ? MAX_WALLS : int'(wall_total[s]);
      covered = 1'b1;
      for (int w = 0; w < n; w++) begin
        if (wall_side(wall_table[s*MAX_WALLS+w], px, py) > 0) covered = 1'b0;
      end
      if (covered) begin
        ans.found = 1'b1;
        ans.sector_index = SEC_IDX_W'(s);
        return ans;
      end
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    edge_rec_t rec;
    if (!rst_n) begin
      for (int i = 0; i < MAX_SECTORS; i++) wall_total[i] = '0;
      sector_cfg = '0;
      owed_answers.delete();
    end else begin
      if (psel && penable && pready && paddr == SECTOR_COUNT_ADDR) begin
        if (pwrite) begin
          sector_cfg = pwdata[4:0];
        end else if (prdata !== {27'b0, sector_cfg}) begin
          errs++;
          $display("%0t: sector_count read mismatch: expected %0d, got %0h",
                   $time, sector_cfg, prdata);
        end
      end
      // result beats belong to older queries, so retire before taking new ones
      if (out_valid && !out_stall) begin
        if (owed_answers.size() == 0) begin
          errs++;
          $display("%0t: unexpected result beat: expected none, got found=%0b index=%0d",
                   $time, out_data.found, out_data.sector_index);
        end else begin
          want = owed_answers.pop_front();
          if (out_data.found !== want.found || out_data.sector_index !== want.sector_index) begin
            errs++;
            $display("%0t: lookup mismatch: expected found=%0b index=%0d, got found=%0b index=%0d",
                     $time, want.found, want.sector_index, out_data.found,
                     out_data.sector_index);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.cmd == CMD_LOAD) begin
          if (int'(in_data.sector_sel) < MAX_SECTORS && int'(in_data.wall_sel) < MAX_WALLS) begin
            rec.ax = in_data.x_start;
            rec.ay = in_data.y_start;
            rec.bx = in_data.x_end;
            rec.by = in_data.y_end;
            wall_table[int'(in_data.sector_sel)*MAX_WALLS + int'(in_data.wall_sel)] = rec;
            if (in_data.wall_last) begin
              wall_total[in_data.sector_sel] = {1'b0, in_data.wall_sel} + 5'd1;
            end
          end
        end else begin
          owed_answers.push_back(locate_point(in_data.point_x, in_data.point_y));
        end
      end
    end
    pending <= owed_answers.size();
    fail_count <= errs;
  end

endmodule

// ===== test/convex_sector_point_locator_test.sv =====
// ----------------------------------------------------------------------------
// convex_sector_point_locator_test
// Drives the sector locator with wall loads and point queries: a short directed
// run over the corner cases, then random convex sectors probed near their inside,
// on their vertices, at wall midpoints and at random, across several sector_count
// values and idle and stall mixes. The checker beside the block judges every result.
// ----------------------------------------------------------------------------
module convex_sector_point_locator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cspl_pkg::*;

  localparam int         NUM_SECTORS   = 16;
  localparam int         NUM_WALLS     = 16;
  localparam int         ITEMS         = 1800;
  localparam int         PHASES        = 12;
  localparam int         HOLD_PHASE    = 4;
  localparam int         HOLD_CYCLES   = 3000;
  localparam int         SETTLE_CYCLES = 300;
  localparam longint     LIMIT_NS      = 64'd50_000_000;
  localparam logic [2:0] SECTOR_COUNT_ADDR = {REG_SECTOR_COUNT, 2'b00};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;

  int unsigned rx_stall_pct = 0;
  int unsigned hold_req_cnt = 0;
  int unsigned tx_idle_pct = 0;
  int          beats_sent = 0;
  logic [4:0]  cfg_now = '0;

  bit slot_written [NUM_SECTORS][NUM_WALLS];
  int poly_n  [NUM_SECTORS];
  int poly_cx [NUM_SECTORS];
  int poly_cy [NUM_SECTORS];
  int poly_r  [NUM_SECTORS];
  int poly_vx [NUM_SECTORS][NUM_WALLS];
  int poly_vy [NUM_SECTORS][NUM_WALLS];

  always #5 clk = ~clk;

  convex_sector_point_locator u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  convex_sector_point_locator_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // cosine of k * 22.5 degrees, scaled by 1024
  function automatic int cos_q10(input int k);
    case (k)
      0:       return 1024;
      1, 15:   return 946;
      2, 14:   return 724;
      3, 13:   return 392;
      4, 12:   return 0;
      5, 11:   return -392;
      6, 10:   return -724;
      7, 9:    return -946;
      default: return -1024;
    endcase
  endfunction

  function automatic int clip16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // all fields random; callers set the ones the command uses
  function automatic in_item_t filler();
    in_item_t it;
    it.cmd        = 1'($urandom);
    it.sector_sel = 4'($urandom);
    it.wall_sel   = 4'($urandom);
    it.wall_last  = 1'($urandom);
    it.x_start    = 16'($urandom);
    it.y_start    = 16'($urandom);
    it.x_end      = 16'($urandom);
    it.y_end      = 16'($urandom);
    it.point_x    = 16'($urandom);
    it.point_y    = 16'($urandom);
    return it;
  endfunction

  task automatic send_beat(input in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  // the last flag is dropped unless every lower slot of the sector holds a wall
  task automatic load_wall(input int s, input int w, input bit last, input int xs,
                           input int ys, input int xe, input int ye);
    in_item_t it;
    bit       lower_ok;
    it = filler();
    lower_ok = 1'b1;
    for (int k = 0; k < w; k++) begin
      if (!slot_written[s][k]) lower_ok = 1'b0;
    end
    it.cmd        = CMD_LOAD;
    it.sector_sel = 4'(s);
    it.wall_sel   = 4'(w);
    it.wall_last  = last && lower_ok;
    it.x_start    = 16'(xs);
    it.y_start    = 16'(ys);
    it.x_end      = 16'(xe);
    it.y_end      = 16'(ye);
    slot_written[s][w] = 1'b1;
    send_beat(it);
  endtask

  task automatic ask_point(input int px, input int py);
    in_item_t it;
    it = filler();
    it.cmd     = CMD_QUERY;
    it.point_x = 16'(px);
    it.point_y = 16'(py);
    send_beat(it);
  endtask

  task automatic apb_access(input bit wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= SECTOR_COUNT_ADDR;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_sector_count(input logic [4:0] value);
    logic [31:0] word;
    word = {27'b0, value};
    if ($urandom_range(1) == 1) word[31:5] = 27'($urandom);
    apb_access(1'b1, word);
    apb_access(1'b0, 32'($urandom));
    cfg_now = value;
  endtask

  // wait for every owed result, then let the block run dry
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // clockwise convex polygon from a subset of the 16-gon directions
  task automatic build_sector(input int s);
    int n, k0, k, w, r, cx, cy, keep;
    bit back;
    r    = int'($urandom_range(16, 12000));
    cx   = int'($urandom_range(0, 40000)) - 20000;
    cy   = int'($urandom_range(0, 40000)) - 20000;
    keep = int'($urandom_range(20, 100));
    n = 0;
    while (n < 3) begin
      n  = 0;
      k0 = int'($urandom_range(0, 15));
      for (int i = 0; i < NUM_WALLS; i++) begin
        k = (k0 - i + 16) % 16;
        if (int'($urandom_range(99)) < keep) begin
          poly_vx[s][n] = clip16(cx + r * cos_q10(k) / 1024);
          poly_vy[s][n] = clip16(cy + r * cos_q10((k + 12) % 16) / 1024);
          n++;
        end
      end
    end
    poly_n[s]  = n;
    poly_cx[s] = cx;
    poly_cy[s] = cy;
    poly_r[s]  = r;
    // backward loads finish on slot zero, which shrinks the count to one
    back = ($urandom_range(4) == 0);
    for (int i = 0; i < n; i++) begin
      w = back ? n - 1 - i : i;
      load_wall(s, w, back ? (i == n - 1) : (w == n - 1), poly_vx[s][w], poly_vy[s][w],
                poly_vx[s][(w + 1) % n], poly_vy[s][(w + 1) % n]);
    end
  endtask

  task automatic probe_sector(input int s);
    int n, i, r, pick, px, py;
    n    = poly_n[s];
    r    = poly_r[s];
    i    = 0;
    pick = 3;
    if (n != 0) begin
      pick = int'($urandom_range(0, 3));
      i    = int'($urandom_range(0, n - 1));
    end
    case (pick)
      0: begin
        px = poly_cx[s] + int'($urandom_range(0, 3 * r)) - 3 * r / 2;
        py = poly_cy[s] + int'($urandom_range(0, 3 * r)) - 3 * r / 2;
      end
      1: begin
        px = poly_vx[s][i];
        py = poly_vy[s][i];
      end
      2: begin
        px = (poly_vx[s][i] + poly_vx[s][(i + 1) % n]) / 2;
        py = (poly_vy[s][i] + poly_vy[s][(i + 1) % n]) / 2;
      end
      default: begin
        px = rand_coord();
        py = rand_coord();
      end
    endcase
    ask_point(clip16(px), clip16(py));
  endtask

  task automatic random_item();
    int s, lim;
    lim = (cfg_now == 0) ? 1 : ((int'(cfg_now) > NUM_SECTORS) ? NUM_SECTORS : int'(cfg_now));
    if ($urandom_range(1) == 0) s = int'($urandom_range(0, lim - 1));
    else s = int'($urandom_range(0, NUM_SECTORS - 1));
    case ($urandom_range(0, 11))
      0, 1:             build_sector(s);
      2, 3, 4, 5, 6, 7, 8: probe_sector(s);
      9:                load_wall(s, int'($urandom_range(0, NUM_WALLS - 1)), 1'($urandom),
                                  rand_coord(), rand_coord(), rand_coord(), rand_coord());
      default:          ask_point(rand_coord(), rand_coord());
    endcase
  endtask

  // receiver side: random stall, plus long hold-offs on request
  initial begin : rx_side
    int unsigned holds_done;
    int unsigned hold_left;
    holds_done = 0;
    hold_left  = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_req_cnt != holds_done) begin
        holds_done = holds_done + 1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left = hold_left - 1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [4:0] next_cfg;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: nothing searched after reset
    ask_point(-32768, 32767);
    settle();
    set_sector_count(5'd1);
    // an empty sector takes any point
    ask_point(32767, -32768);
    // full-range clockwise square in sector 0
    load_wall(0, 0, 1'b0, -32768, -32768, -32768, 32767);
    load_wall(0, 1, 1'b0, -32768, 32767, 32767, 32767);
    load_wall(0, 2, 1'b0, 32767, 32767, 32767, -32768);
    load_wall(0, 3, 1'b1, 32767, -32768, -32768, -32768);
    ask_point(0, 0);
    ask_point(32767, 32767);
    ask_point(-32768, -32768);
    ask_point(-32768, 32767);
    // shrink sector 0 to the half plane x >= 0
    load_wall(0, 0, 1'b1, 0, -16, 0, 16);
    ask_point(-32768, 0);
    ask_point(0, 0);
    ask_point(1, -32768);
    // grow back: slots above the old count kept their walls
    load_wall(0, 3, 1'b1, 32767, -32768, -32768, -32768);
    ask_point(-1, 5);
    load_wall(15, 15, 1'b0, 32767, -32768, -32768, 32767);
    settle();
    set_sector_count(5'd2);
    ask_point(-32768, 0);
    settle();
    set_sector_count(5'd31);
    ask_point(-5, -5);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0:       next_cfg = 5'd16;
        1:       next_cfg = 5'd2;
        2:       next_cfg = 5'd31;
        3:       next_cfg = 5'd0;
        4:       next_cfg = 5'd16;
        5:       next_cfg = 5'd1;
        6:       next_cfg = 5'd17;
        7:       next_cfg = 5'd15;
        default: next_cfg = 5'($urandom_range(0, 31));
      endcase
      set_sector_count(next_cfg);
      case (ph % 4)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 0;
        end
        1: begin
          tx_idle_pct = 86;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 86;
        end
        default: begin
          tx_idle_pct = 33;
          rx_stall_pct <= 33;
        end
      endcase
      if (ph == HOLD_PHASE) begin
        // queries pile up behind a long receiver hold-off
        hold_req_cnt <= hold_req_cnt + 1;
        repeat (30) probe_sector(int'($urandom_range(0, NUM_SECTORS - 1)));
      end
      while (beats_sent < (ph + 1) * ITEMS / PHASES) random_item();
    end

    settle();
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
